// ===== rtl/quadrature_travel_monitor_assert.svh =====
// Assertion macros for the quadrature travel monitor checker.
// Depends on: nothing; expects clk and rst_n in the scope of use.
`ifndef QUADRATURE_TRAVEL_MONITOR_ASSERT_SVH
`define QUADRATURE_TRAVEL_MONITOR_ASSERT_SVH

// Clocked check, quiet while reset is asserted
`define QTM_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define QTM_CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/qtm_pkg.sv =====
// Shared types, codes and microcode ROM for the quadrature travel monitor.
// Depends on: nothing.
package qtm_pkg;

  localparam int STAMP_WIDTH_DEFAULT = 32;
  localparam logic [15:0] END_COUNT_RESET = 16'd3000;

  // Locked direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_RL   = 2'd1;
  localparam logic [1:0] DIR_LR   = 2'd2;

  // Edge codes
  localparam logic [2:0] EDGE_NONE   = 3'd0;
  localparam logic [2:0] EDGE_A_RISE = 3'd1;
  localparam logic [2:0] EDGE_A_FALL = 3'd2;
  localparam logic [2:0] EDGE_B_RISE = 3'd3;
  localparam logic [2:0] EDGE_B_FALL = 3'd4;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  // Microcode step addresses
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ST_FETCH    = 4'd0;
  localparam step_t ST_CLASSIFY = 4'd1;
  localparam step_t ST_BRANCH   = 4'd2;
  localparam step_t ST_ACCUM    = 4'd3;
  localparam step_t ST_CHECK    = 4'd4;
  localparam step_t ST_DIV_INIT = 4'd5;
  localparam step_t ST_DIV_STEP = 4'd6;
  localparam step_t ST_DIV_END  = 4'd7;
  localparam step_t ST_EMIT     = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_CLASSIFY, OP_ACCUM,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS, C_NO_INPUT, C_NO_COUNT, C_NOT_END, C_DIV_BUSY, C_OUT_FULL
  } cond_t;

  // One control word: datapath op, branch condition, taken and fall-through steps
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t taken;
    step_t next;
  } ctrl_word_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic count_pend;
    logic at_end;
    logic div_busy;
    logic out_full;
  } seq_status_t;

  // Microcode program
  function automatic ctrl_word_t ucode_rom(input step_t addr);
    ctrl_word_t cw;
    unique case (addr)
      ST_FETCH:    cw = '{OP_LOAD,     C_NO_INPUT, ST_FETCH,    ST_CLASSIFY};
      ST_CLASSIFY: cw = '{OP_CLASSIFY, C_ALWAYS,   ST_BRANCH,   ST_BRANCH};
      ST_BRANCH:   cw = '{OP_NOP,      C_NO_COUNT, ST_EMIT,     ST_ACCUM};
      ST_ACCUM:    cw = '{OP_ACCUM,    C_ALWAYS,   ST_CHECK,    ST_CHECK};
      ST_CHECK:    cw = '{OP_NOP,      C_NOT_END,  ST_EMIT,     ST_DIV_INIT};
      ST_DIV_INIT: cw = '{OP_DIV_INIT, C_ALWAYS,   ST_DIV_STEP, ST_DIV_STEP};
      ST_DIV_STEP: cw = '{OP_DIV_STEP, C_DIV_BUSY, ST_DIV_STEP, ST_DIV_END};
      ST_DIV_END:  cw = '{OP_DIV_END,  C_ALWAYS,   ST_EMIT,     ST_EMIT};
      ST_EMIT:     cw = '{OP_EMIT,     C_OUT_FULL, ST_EMIT,     ST_FETCH};
      default:     cw = '{OP_NOP,      C_ALWAYS,   ST_FETCH,    ST_FETCH};
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/quadrature_travel_monitor.sv =====
// Channel   Handshake          Beat contents
// in        in_valid/ready     action, which_signal, level_a, level_b, timestamp
// out       out_valid/ready    pulse, flags, average_period, edge_count, armed
// cfg       cfg_we             end_count (16 bit), written at once
//
// After accept a beat passes the classify and branch steps to the emit step; one that
// counts a reference edge adds the accumulate and check steps, one that ends travel
// also the divider steps (one quotient bit a cycle); one microcode step per cycle.
// Reset (rst_n low, synchronous) disarms, clears count, total, flags and mean, end_count to 3000.
// in_ready is high only in the fetch step; a stalled result holds the sequencer
// in the emit step until out_ready.
//
// Top level of the quadrature travel monitor. Depends on: qtm_pkg, qtm_seq, qtm_dp.
module quadrature_travel_monitor
  import qtm_pkg::*;
#(
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic        in_which_signal,
  input  logic        in_level_a,
  input  logic        in_level_b,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pulse,
  output logic        out_direction_error,
  output logic        out_end_of_travel,
  output logic [31:0] out_average_period,
  output logic [15:0] out_edge_count,
  output logic        out_armed
);

  op_t         op;
  seq_status_t status;

  // Control program
  qtm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .op     (op)
  );

  // Datapath
  qtm_dp #(
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op                  (op),
    .status              (status),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_which_signal     (in_which_signal),
    .in_level_a          (in_level_a),
    .in_level_b          (in_level_b),
    .in_timestamp        (in_timestamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pulse           (out_pulse),
    .out_direction_error (out_direction_error),
    .out_end_of_travel   (out_end_of_travel),
    .out_average_period  (out_average_period),
    .out_edge_count      (out_edge_count),
    .out_armed           (out_armed)
  );

endmodule

// ===== rtl/qtm_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on: qtm_pkg.
module qtm_seq
  import qtm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  seq_status_t status,
  output op_t         op
);

  step_t      step_r, step_nxt;
  ctrl_word_t cw;
  logic       jump;

  assign cw = ucode_rom(step_r);
  assign op = cw.op;

  // Branch condition select
  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !status.in_valid;
      C_NO_COUNT: jump = !status.count_pend;
      C_NOT_END:  jump = !status.at_end;
      C_DIV_BUSY: jump = status.div_busy;
      C_OUT_FULL: jump = status.out_full;
      default:    jump = 1'b1;
    endcase
    step_nxt = jump ? cw.taken : cw.next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/qtm_dp.sv =====
// Datapath: item latch, measurement state, bit-serial divider, result register.
// Depends on: qtm_pkg; driven one op per cycle by qtm_seq.
module qtm_dp
  import qtm_pkg::*;
#(
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  op_t         op,
  output seq_status_t status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic        in_which_signal,
  input  logic        in_level_a,
  input  logic        in_level_b,
  input  logic [31:0] in_timestamp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_pulse,
  output logic        out_direction_error,
  output logic        out_end_of_travel,
  output logic [31:0] out_average_period,
  output logic [15:0] out_edge_count,
  output logic        out_armed
);

  localparam int SW  = STAMP_WIDTH;
  localparam int MW  = (SW > 32) ? SW : 32;
  localparam int DCW = $clog2(SW + 1);

  // Item latch
  logic          act_r, src_r, la_r, lb_r;
  logic [SW-1:0] now_r;
  logic [MW-1:0] ts_ext;

  // Measurement state
  logic          running_r, running_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [2:0]    ref_r, ref_nxt;
  logic [15:0]   count_r, count_nxt;
  logic [SW-1:0] total_r, total_nxt;
  logic [SW-1:0] prev_r, prev_nxt;
  logic [SW-1:0] delta_r, delta_nxt;
  logic          err_r, err_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   mean_r, mean_nxt;
  logic          pulse_r, pulse_nxt;
  logic          pend_r, pend_nxt;
  logic [15:0]   end_count_r;

  // Divider
  logic [15:0]    rem_r, rem_nxt;
  logic [SW-1:0]  quo_r, quo_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic [16:0]    trial, diff;
  logic           fits;
  logic [MW-1:0]  quo_ext;

  // Edge decode
  logic [2:0] edge_code, ref_eff;
  logic [1:0] dir_code;

  // Result register
  logic out_valid_r, out_load;
  logic out_full;

  assign ts_ext  = MW'(in_timestamp);
  assign quo_ext = MW'(quo_r);
  assign in_ready = (op == OP_LOAD);
  assign out_full = out_valid_r && !out_ready;
  assign out_load = (op == OP_EMIT) && !out_full;

  assign status = '{in_valid:   in_valid,
                    count_pend: pend_r,
                    at_end:     (count_r >= end_count_r),
                    div_busy:   (dcnt_r != DCW'(1)),
                    out_full:   out_full};

  // Edge classification from the latched beat
  always_comb begin
    if (!src_r) begin
      edge_code = la_r ? EDGE_A_RISE : EDGE_A_FALL;
    end else begin
      edge_code = lb_r ? EDGE_B_RISE : EDGE_B_FALL;
    end
    ref_eff = (ref_r == EDGE_NONE) ? edge_code : ref_r;
    if (edge_code == EDGE_A_RISE || edge_code == EDGE_B_FALL) begin
      dir_code = lb_r ? DIR_LR : DIR_RL;
    end else begin
      dir_code = lb_r ? DIR_RL : DIR_LR;
    end
  end

  // One restoring divide step
  assign trial = {rem_r, quo_r[SW-1]};
  assign fits  = (trial >= {1'b0, count_r});
  assign diff  = trial - {1'b0, count_r};

  // Op execution
  always_comb begin
    running_nxt = running_r;
    dir_nxt     = dir_r;
    ref_nxt     = ref_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    prev_nxt    = prev_r;
    delta_nxt   = delta_r;
    err_nxt     = err_r;
    done_nxt    = done_r;
    mean_nxt    = mean_r;
    pulse_nxt   = pulse_r;
    pend_nxt    = pend_r;
    rem_nxt     = rem_r;
    quo_nxt     = quo_r;
    dcnt_nxt    = dcnt_r;
    unique case (op)
      OP_CLASSIFY: begin
        pulse_nxt = 1'b0;
        pend_nxt  = 1'b0;
        if (act_r == ACT_START) begin
          // start only re-arms an idle block
          if (!running_r) begin
            err_nxt     = 1'b0;
            done_nxt    = 1'b0;
            running_nxt = 1'b1;
            dir_nxt     = DIR_NONE;
            count_nxt   = '0;
            mean_nxt    = '0;
            total_nxt   = '0;
            prev_nxt    = '0;
            ref_nxt     = EDGE_NONE;
          end
        end else if (running_r) begin
          pulse_nxt = 1'b1;
          ref_nxt   = ref_eff;
          if (dir_r != dir_code) begin
            if (dir_r == DIR_NONE) begin
              prev_nxt = now_r;
              dir_nxt  = dir_code;
            end else begin
              err_nxt     = 1'b1;
              running_nxt = 1'b0;
            end
          end else if (edge_code == ref_eff) begin
            pend_nxt  = 1'b1;
            delta_nxt = now_r - prev_r;
          end
        end
      end
      OP_ACCUM: begin
        total_nxt = total_r + delta_r;
        prev_nxt  = now_r;
        count_nxt = count_r + 16'd1;
      end
      OP_DIV_INIT: begin
        done_nxt    = 1'b1;
        running_nxt = 1'b0;
        rem_nxt     = '0;
        quo_nxt     = total_r;
        dcnt_nxt    = DCW'(SW);
      end
      OP_DIV_STEP: begin
        rem_nxt  = fits ? diff[15:0] : trial[15:0];
        quo_nxt  = {quo_r[SW-2:0], fits};
        dcnt_nxt = dcnt_r - DCW'(1);
      end
      OP_DIV_END: begin
        // a zero count gives a zero mean
        mean_nxt = (count_r == 16'd0) ? 32'd0 : quo_ext[31:0];
      end
      default: begin
      end
    endcase
  end

  // Item latch, payload only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action;
      src_r <= in_which_signal;
      la_r  <= in_level_a;
      lb_r  <= in_level_b;
      now_r <= ts_ext[SW-1:0];
    end
  end

  // Measurement state and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      dir_r       <= DIR_NONE;
      ref_r       <= EDGE_NONE;
      count_r     <= '0;
      total_r     <= '0;
      prev_r      <= '0;
      err_r       <= 1'b0;
      done_r      <= 1'b0;
      mean_r      <= '0;
      pulse_r     <= 1'b0;
      pend_r      <= 1'b0;
      dcnt_r      <= DCW'(1);
      end_count_r <= END_COUNT_RESET;
    end else begin
      running_r <= running_nxt;
      dir_r     <= dir_nxt;
      ref_r     <= ref_nxt;
      count_r   <= count_nxt;
      total_r   <= total_nxt;
      prev_r    <= prev_nxt;
      err_r     <= err_nxt;
      done_r    <= done_nxt;
      mean_r    <= mean_nxt;
      pulse_r   <= pulse_nxt;
      pend_r    <= pend_nxt;
      dcnt_r    <= dcnt_nxt;
      if (cfg_we) begin
        end_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    delta_r <= delta_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pulse           <= pulse_r;
      out_direction_error <= err_r;
      out_end_of_travel   <= done_r;
      out_average_period  <= mean_r;
      out_edge_count      <= count_r;
      out_armed           <= running_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/qtm_checker.sv =====
// Port-level checks for the quadrature travel monitor, bound to the top level.
// Depends on: quadrature_travel_monitor_assert.svh.
`include "quadrature_travel_monitor_assert.svh"

module qtm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_direction_error,
  input logic        out_end_of_travel,
  input logic [31:0] out_average_period,
  input logic [15:0] out_edge_count,
  input logic        out_armed
);

  // A held result beat stays valid and keeps its edge count
  `QTM_CHK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_edge_count), "result beat changed while stalled")

  // Error and end of travel both disarm, so they never show together
  `QTM_CHK(a_flags_excl, out_valid |-> !(out_direction_error && out_end_of_travel), "error and end of travel both set")

  // A running measurement carries no sticky flag
  `QTM_CHK(a_armed_clean, out_valid && out_armed |-> !out_direction_error && !out_end_of_travel, "armed with a sticky flag")

  // The mean is only set at end of travel
  `QTM_CHK(a_mean_zero, out_valid && !out_end_of_travel |-> out_average_period == 32'd0, "mean set before end of travel")

  // One beat at a time: ready drops after an accept
  `QTM_CHK(a_one_beat, in_valid && in_ready |=> !in_ready, "second beat accepted back to back")

endmodule

bind quadrature_travel_monitor qtm_checker u_chk (.*);

// ===== tb/quadrature_travel_monitor_test.sv =====
// Testbench for the quadrature travel monitor: directed and random encoder beats.
// A status predictor inside a small scoreboard class checks every result beat.
// Depends on: qtm_pkg and quadrature_travel_monitor.
`timescale 1ns / 100ps

module quadrature_travel_monitor_test
  import qtm_pkg::*;
();

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_BEATS = 1600;

  // One input beat and one result beat
  typedef struct packed {
    logic        action;
    logic        which_signal;
    logic        level_a;
    logic        level_b;
    logic [31:0] timestamp;
  } encoder_beat_t;

  typedef struct packed {
    logic        pulse;
    logic        direction_error;
    logic        end_of_travel;
    logic [31:0] average_period;
    logic [15:0] edge_count;
    logic        armed;
  } travel_status_t;

  // Travel status predictor and result checker
  class travel_scoreboard;
    logic [15:0]    end_count;
    bit             running;
    logic [1:0]     dir_lock;
    logic [2:0]     ref_edge;
    logic [15:0]    ref_count;
    logic [31:0]    elapsed_sum;
    logic [31:0]    last_stamp;
    bit             dir_error;
    bit             travel_done;
    logic [31:0]    mean_period;
    travel_status_t expected_status[$];
    int             failures;

    function new();
      end_count   = END_COUNT_RESET;
      running     = 1'b0;
      dir_lock    = DIR_NONE;
      ref_edge    = EDGE_NONE;
      ref_count   = '0;
      elapsed_sum = '0;
      last_stamp  = '0;
      dir_error   = 1'b0;
      travel_done = 1'b0;
      mean_period = '0;
      failures    = 0;
    endfunction

    // Advance the predicted state by one accepted beat, queue the status it gives
    function void predict_status(encoder_beat_t b);
      travel_status_t s;
      logic [2:0] edge_kind;
      logic [1:0] heading;
      s.pulse = 1'b0;
      if (b.action == ACT_START) begin
        // a start while armed is ignored
        if (!running) begin
          dir_error   = 1'b0;
          travel_done = 1'b0;
          running     = 1'b1;
          dir_lock    = DIR_NONE;
          ref_count   = '0;
          mean_period = '0;
          elapsed_sum = '0;
          last_stamp  = '0;
          ref_edge    = EDGE_NONE;
        end
      end else if (running) begin
        s.pulse = 1'b1;
        if (b.which_signal == 1'b0)
          edge_kind = b.level_a ? EDGE_A_RISE : EDGE_A_FALL;
        else
          edge_kind = b.level_b ? EDGE_B_RISE : EDGE_B_FALL;
        if (ref_edge == EDGE_NONE)
          ref_edge = edge_kind;
        if (edge_kind == EDGE_A_RISE || edge_kind == EDGE_B_FALL)
          heading = b.level_b ? DIR_LR : DIR_RL;
        else
          heading = b.level_b ? DIR_RL : DIR_LR;
        if (dir_lock != heading) begin
          if (dir_lock == DIR_NONE) begin
            // first edge: lock direction, stamp only
            last_stamp = b.timestamp;
            dir_lock   = heading;
          end else begin
            dir_error = 1'b1;
            running   = 1'b0;
          end
        end else if (edge_kind == ref_edge) begin
          // elapsed time and total both wrap at 32 bits
          elapsed_sum = elapsed_sum + (b.timestamp - last_stamp);
          last_stamp  = b.timestamp;
          ref_count   = ref_count + 16'd1;
          if (ref_count >= end_count) begin
            travel_done = 1'b1;
            mean_period = (ref_count != 0) ? elapsed_sum / ref_count : '0;
            running     = 1'b0;
          end
        end
      end
      s.direction_error = dir_error;
      s.end_of_travel   = travel_done;
      s.average_period  = mean_period;
      s.edge_count      = ref_count;
      s.armed           = running;
      expected_status.push_back(s);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        failures++;
      end
    endfunction

    // Compare one result beat against the oldest expected status
    function void check_status(travel_status_t r);
      travel_status_t e;
      if (expected_status.size() == 0) begin
        $error("result beat with no expected status");
        failures++;
        return;
      end
      e = expected_status.pop_front();
      compare_field("out_pulse", e.pulse, r.pulse);
      compare_field("out_direction_error", e.direction_error, r.direction_error);
      compare_field("out_end_of_travel", e.end_of_travel, r.end_of_travel);
      compare_field("out_average_period", e.average_period, r.average_period);
      compare_field("out_edge_count", e.edge_count, r.edge_count);
      compare_field("out_armed", e.armed, r.armed);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic        in_which_signal = 1'b0;
  logic        in_level_a = 1'b0;
  logic        in_level_b = 1'b0;
  logic [31:0] in_timestamp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_pulse;
  logic        out_direction_error;
  logic        out_end_of_travel;
  logic [31:0] out_average_period;
  logic [15:0] out_edge_count;
  logic        out_armed;

  travel_scoreboard sb = new();

  // Encoder model for stimulus: Gray position, travel direction, running timer
  logic [1:0]  gen_pos = '0;
  bit          gen_fwd = 1'b1;
  logic [31:0] stamp_now = '0;
  bit          quiet = 1'b0;
  int          idle_cycles = 0;
  int          counted = 0;

  quadrature_travel_monitor uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_which_signal    (in_which_signal),
    .in_level_a         (in_level_a),
    .in_level_b         (in_level_b),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pulse          (out_pulse),
    .out_direction_error(out_direction_error),
    .out_end_of_travel  (out_end_of_travel),
    .out_average_period (out_average_period),
    .out_edge_count     (out_edge_count),
    .out_armed          (out_armed)
  );

  always #4 clk = ~clk;

  // Result side: random back-pressure, full speed in the quiet stretch
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 22);
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_status('{out_pulse, out_direction_error, out_end_of_travel,
                        out_average_period, out_edge_count, out_armed});
  end

  // Watchdog: too long with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Next quadrature edge in the given direction, timer advanced by delta
  function automatic encoder_beat_t next_edge(bit fwd, logic [31:0] delta);
    encoder_beat_t b;
    logic old_a;
    old_a = gen_pos[0] ^ gen_pos[1];
    gen_pos = fwd ? gen_pos + 2'd1 : gen_pos - 2'd1;
    stamp_now = stamp_now + delta;
    b.action       = ACT_EDGE;
    b.level_a      = gen_pos[0] ^ gen_pos[1];
    b.level_b      = gen_pos[1];
    b.which_signal = (old_a == b.level_a);
    b.timestamp    = stamp_now;
    return b;
  endfunction

  function automatic encoder_beat_t random_beat(logic act);
    encoder_beat_t b;
    b.action       = act;
    b.which_signal = 1'($urandom_range(1));
    b.level_a      = 1'($urandom_range(1));
    b.level_b      = 1'($urandom_range(1));
    b.timestamp    = $urandom;
    return b;
  endfunction

  // Mostly short intervals, some long ones, a few that force wrap
  function automatic logic [31:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(4000, 1);
    if (r < 90) return $urandom_range(1 << 20, 0);
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_end_count();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 16'($urandom_range(4, 1));
    if (r < 80) return 16'($urandom_range(12, 5));
    if (r < 95) return 16'($urandom_range(40, 13));
    return 16'($urandom_range(65535, 41));
  endfunction

  // Drive one beat, hold it until accepted, then predict its status
  task automatic send_beat(encoder_beat_t b);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_action       <= b.action;
    in_which_signal <= b.which_signal;
    in_level_a      <= b.level_a;
    in_level_b      <= b.level_b;
    in_timestamp    <= b.timestamp;
    do @(posedge clk); while (!in_ready);
    sb.predict_status(b);
  endtask

  // Stop sending and wait until every expected status has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_end_count(logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.end_count = value;
  endtask

  initial begin
    encoder_beat_t b;
    int phase_len;
    int r;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset end count: edge while disarmed, start, start while armed,
    // one counted reference edge across timer wrap, then a reversal
    send_beat('{ACT_EDGE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF});
    send_beat('{ACT_START, 1'b0, 1'b0, 1'b0, 32'h0});
    send_beat('{ACT_START, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF});
    gen_pos = 2'd0;
    stamp_now = 32'hFFFF_FFE0;
    repeat (5) send_beat(next_edge(1'b1, 32'h10));
    send_beat(next_edge(1'b0, 32'd5));
    send_beat(next_edge(1'b1, 32'd5));

    // End count zero: the first counted reference edge ends travel
    drain_results();
    write_end_count(16'd0);
    send_beat('{ACT_START, 1'b1, 1'b0, 1'b1, 32'h5A5A_5A5A});
    gen_pos = 2'd2;
    stamp_now = '0;
    repeat (5) send_beat(next_edge(1'b0, 32'd1000));
    send_beat('{ACT_START, 1'b0, 1'b1, 1'b0, 32'hA5A5_A5A5});

    // End count one with maximal intervals: the counted interval wraps
    drain_results();
    write_end_count(16'd1);
    gen_pos = 2'd3;
    repeat (5) send_beat(next_edge(1'b1, 32'hFFFF_FFFF));
    send_beat(next_edge(1'b1, 32'd7));

    // Largest end count
    drain_results();
    write_end_count(16'hFFFF);
    send_beat('{ACT_START, 1'b0, 1'b0, 1'b0, 32'h0});
    repeat (3) send_beat(next_edge(1'b1, 32'd123));

    // Random phases: mostly clean sweeps, some reversals, starts and noise
    while (counted < RANDOM_BEATS) begin
      drain_results();
      write_end_count(pick_end_count());
      phase_len = $urandom_range(120, 40);
      repeat (phase_len) begin
        quiet = (counted >= 500 && counted < 800);
        r = $urandom_range(99);
        if (!sb.running) begin
          if (r < 80) begin
            gen_pos   = 2'($urandom_range(3));
            gen_fwd   = 1'($urandom_range(1));
            stamp_now = $urandom;
            b = random_beat(ACT_START);
          end else begin
            b = random_beat(ACT_EDGE);
          end
        end else begin
          if (r < 86)
            b = next_edge(gen_fwd, pick_delta());
          else if (r < 90)
            b = next_edge(!gen_fwd, pick_delta());
          else if (r < 94)
            b = random_beat(ACT_START);
          else
            b = random_beat(ACT_EDGE);
        end
        send_beat(b);
        counted++;
      end
    end

    drain_results();
    quiet = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.expected_status.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
